// ----- sv/cht_pkg.sv -----
package cht_pkg;

	// table geometry
	localparam int BUCKETS    = 64;
	localparam int WAYS       = 4;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;

	localparam int SLOTS    = BUCKETS * WAYS;
	localparam int BUCKET_W = $clog2(BUCKETS);
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int COUNT_W  = $clog2(SLOTS + 1);

	// key and value bits actually kept (the fields are 32 bits wide)
	localparam int KEY_W = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int VAL_W = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam int ENTRY_W = KEY_W + VAL_W;

	// action codes
	localparam logic [1:0] ACT_PUT    = 2'd0;
	localparam logic [1:0] ACT_GET    = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic [1:0]         action;
		logic [31:0]        key;
		logic signed [31:0] value;
	} hash_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_value;
		logic [8:0]         entry_count;
	} hash_rsp_t;

	// controller to datapath
	typedef struct packed {
		logic             load;
		logic             rd_en;
		logic [WAY_W-1:0] rd_way;
		logic             commit;
	} cht_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_busy;
	} cht_sts_t;

endpackage

// ----- sv/chained_hash_table.sv -----
// key-value table of BUCKETS buckets with WAYS slots each; a request carries an
// action (put, get, remove), a key and a value, and every request gives exactly one
// response with a status, the read value on a get hit and the entry count after
// the request. the bucket is the key's low bits. after its transfer, a request
// runs in steps: the slots of the bucket are read one per cycle through the
// single read port of the slot memory, a drain state waits for the last read,
// and a commit state writes back and loads the response register.
// a new request is taken in the idle cycle after the previous one has committed,
// even while its response still waits for a transfer; commit stalls only if the
// previous response is still unclaimed. slot valid bits and the count are
// cleared by reset, no clearing pass is needed.
module chained_hash_table (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               req_valid,
	output logic               req_ready,
	input  cht_pkg::hash_req_t req,
	// response channel
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output cht_pkg::hash_rsp_t rsp
);
	import cht_pkg::*;

	// command and status between sequencer and datapath
	cht_cmd_t cmd;
	cht_sts_t sts;

	// sequencer: idle, bucket scan, read drain, commit
	cht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: slot memory, valid bits, match logic, response register
	cht_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ----- sv/cht_ram.sv -----
module cht_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/cht_ctrl.sv -----
module cht_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  cht_pkg::cht_sts_t sts,
	output cht_pkg::cht_cmd_t cmd
);
	import cht_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DRAIN  = 2'd2;
	localparam logic [1:0] S_COMMIT = 2'd3;

	logic [1:0]       state_q;
	logic [1:0]       state_d;
	logic [WAY_W-1:0] way_q;
	logic [WAY_W-1:0] way_d;

	always_comb begin
		state_d    = state_q;
		way_d      = way_q;
		req_ready  = 1'b0;
		cmd.load   = 1'b0;
		cmd.rd_en  = 1'b0;
		cmd.rd_way = way_q;
		cmd.commit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					way_d    = '0;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.rd_en = 1'b1;
				if (way_q == WAY_W'(WAYS - 1)) begin
					state_d = S_DRAIN;
				end else begin
					way_d = way_q + WAY_W'(1);
				end
			end
			S_DRAIN: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			way_q   <= '0;
		end else begin
			state_q <= state_d;
			way_q   <= way_d;
		end
	end

endmodule

// ----- sv/cht_dp.sv -----
module cht_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  cht_pkg::hash_req_t req,
	input  cht_pkg::cht_cmd_t cmd,
	output cht_pkg::cht_sts_t sts,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output cht_pkg::hash_rsp_t rsp
);
	import cht_pkg::*;

	// latched item
	logic [1:0]       act_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;

	// slot state
	logic [SLOTS-1:0]   valid_q;
	logic [COUNT_W-1:0] count_q;

	// scan results
	logic             rd_s1;
	logic [WAY_W-1:0] rd_way_s1;
	logic             rd_vld_s1;
	logic             hit_q;
	logic [WAY_W-1:0] hit_way_q;
	logic [VAL_W-1:0] hit_val_q;
	logic             free_q;
	logic [WAY_W-1:0] free_way_q;

	// output register
	logic      rsp_valid_q;
	hash_rsp_t rsp_q;

	logic [SLOT_W-1:0]  base;
	logic [SLOT_W-1:0]  rd_addr;
	logic [ENTRY_W-1:0] rd_data;
	logic [KEY_W-1:0]   rd_key;
	logic [VAL_W-1:0]   rd_val;
	logic               wr_en;
	logic [SLOT_W-1:0]  wr_addr;
	logic [SLOT_W-1:0]  hit_addr;
	logic               set_valid;
	logic               clr_valid;
	logic [COUNT_W-1:0] count_d;
	logic [1:0]         status_d;
	logic [VAL_W-1:0]   rdval_d;

	assign base     = SLOT_W'(key_q[BUCKET_W-1:0]) * SLOT_W'(WAYS);
	assign rd_addr  = base + SLOT_W'(cmd.rd_way);
	assign hit_addr = base + SLOT_W'(hit_way_q);
	assign wr_addr  = hit_q ? hit_addr : (base + SLOT_W'(free_way_q));
	assign rd_key   = rd_data[ENTRY_W-1:VAL_W];
	assign rd_val   = rd_data[VAL_W-1:0];

	cht_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata ({key_q, val_q}),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// item latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= req.action;
			key_q <= req.key[KEY_W-1:0];
			val_q <= req.value[VAL_W-1:0];
		end
	end

	// read pipeline alignment
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		rd_way_s1 <= cmd.rd_way;
		rd_vld_s1 <= valid_q[rd_addr];
	end

	// first matching way and lowest free way
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.load) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (rd_s1) begin
			if (rd_vld_s1) begin
				if (!hit_q && rd_key == key_q) begin
					hit_q <= 1'b1;
				end
			end else if (!free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s1) begin
			if (rd_vld_s1) begin
				if (!hit_q && rd_key == key_q) begin
					hit_way_q <= rd_way_s1;
					hit_val_q <= rd_val;
				end
			end else if (!free_q) begin
				free_way_q <= rd_way_s1;
			end
		end
	end

	// action resolution
	always_comb begin
		wr_en     = 1'b0;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		count_d   = count_q;
		status_d  = ST_ABSENT;
		rdval_d   = '0;
		unique case (act_q)
			ACT_PUT: begin
				if (hit_q) begin
					wr_en    = cmd.commit;
					status_d = ST_OK;
				end else if (free_q) begin
					wr_en     = cmd.commit;
					set_valid = cmd.commit;
					count_d   = count_q + COUNT_W'(1);
					status_d  = ST_OK;
				end else begin
					status_d = ST_FULL;
				end
			end
			ACT_GET: begin
				if (hit_q) begin
					rdval_d  = hit_val_q;
					status_d = ST_OK;
				end
			end
			ACT_REMOVE: begin
				if (hit_q) begin
					clr_valid = cmd.commit;
					if (count_q != '0) begin
						count_d = count_q - COUNT_W'(1);
					end
					status_d = ST_OK;
				end
			end
			default: begin
				status_d = ST_ABSENT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_d;
			if (set_valid) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (clr_valid) begin
				valid_q[hit_addr] <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.status      <= status_d;
			rsp_q.read_value  <= 32'(rdval_d);
			rsp_q.entry_count <= 9'(count_d);
		end
	end

	assign sts.out_busy = rsp_valid_q & ~rsp_ready;
	assign rsp_valid    = rsp_valid_q;
	assign rsp          = rsp_q;

endmodule
